// ===== hw/rtl/nec_pkg.sv =====
// Package for the NLMS echo canceller: register indexes, fixed-point constants
// and channel field widths. No dependencies.
`timescale 1ns / 1ps
package nec_pkg;

  localparam int TAPS_DEFAULT = 96;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STRENGTH = 2'd1;
  localparam logic [6:0] STRENGTH_RESET = 7'd70;
  localparam logic [6:0] STRENGTH_MAX   = 7'd100;

  // sample and tap formats
  localparam int SAMPLE_W = 16;
  localparam int TAP_W    = 24;
  localparam int GAIN_W   = 16;

  // Q.30 epsilon, Q.20 tap limit, update error limit (16.0 in Q.35)
  localparam logic [15:0] EPS_Q30 = 16'd42950;
  localparam logic signed [25:0] TAP_LIMIT = 26'sd1677722;
  localparam int UE_W = 40;
  localparam logic [UE_W-1:0] UPD_ERR_LIMIT = 40'h80_0000_0000;

  // step numerator is 280 + 4*p over 10000
  localparam logic [9:0]  STEP_BASE = 10'd280;
  localparam logic [13:0] STEP_DEN  = 14'd10000;

  // tap change saturates here: anything this large clamps the tap anyway
  localparam int Q_BITS = 22;

endpackage

// ===== hw/rtl/nec_item_if.sv =====
// Input channel of the echo canceller: one mic/reference sample pair per transaction.
// Depends on nec_pkg.
`timescale 1ns / 1ps
interface nec_item_if;
  import nec_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] mic_sample;
  logic signed [SAMPLE_W-1:0] ref_sample;
  logic                       adapt;
  logic        [GAIN_W-1:0]   error_gain;
  modport source (output valid, mic_sample, ref_sample, adapt, error_gain, input ready);
  modport sink   (input valid, mic_sample, ref_sample, adapt, error_gain, output ready);
endinterface

// ===== hw/rtl/nec_result_if.sv =====
// Output channel of the echo canceller: one cancelled sample per transaction.
// Depends on nec_pkg.
`timescale 1ns / 1ps
interface nec_result_if;
  import nec_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] out_sample;
  modport source (output valid, out_sample, input ready);
  modport sink   (input valid, out_sample, output ready);
endinterface

// ===== hw/rtl/nec_cfg_if.sv =====
// Register write channel of the echo canceller.
// Depends on nec_pkg.
`timescale 1ns / 1ps
interface nec_cfg_if;
  import nec_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/nlms_echo_canceller_unit.sv =====
// NLMS echo canceller top level: history and tap memories, multiply/accumulate
// logic and a bit-serial divider under a state machine.
// Depends on nec_pkg, nec_item_if, nec_result_if, nec_cfg_if.
//
//   channel  | dir | transaction carries
//   ---------+-----+-----------------------------------------------------
//   item     | in  | mic_sample, ref_sample, adapt, error_gain
//   result   | out | out_sample
//   cfg      | in  | index, data (0: enable, 1: strength)
//
// From accept to ready again: pass through goes straight to the finish step;
// cancellation makes a dot product pass over the memories; with adapt set, each
// tap then goes through the one-bit-per-cycle divider (skipped when the change
// saturates). After reset a clearing pass zeroes both memories before the first
// item. item.ready is high only while idle; a held result stalls the finish
// step until result.ready. cfg is always ready.
`timescale 1ns / 1ps
module nlms_echo_canceller_unit #(
  parameter int TAPS = nec_pkg::TAPS_DEFAULT
) (
  input logic         clk,
  input logic         rst,
  nec_item_if.sink    item,
  nec_result_if.source result,
  nec_cfg_if.sink     cfg
);
  import nec_pkg::*;

  localparam int IW   = $clog2(TAPS);
  localparam int AW   = 39 + IW;           // estimate accumulator
  localparam int ERRW = AW + 1;
  localparam int EW   = 31 + IW;           // energy accumulator
  localparam int DW   = EW + 14;           // 10000 * energy
  localparam int NW   = 10 + UE_W;         // step numerator * error
  localparam int PW   = NW + SAMPLE_W;     // times |x|
  localparam int CW   = DW + Q_BITS;       // divider width
  localparam int GW   = ERRW + GAIN_W;
  localparam int MW   = GW + 1 - 35;
  localparam logic [IW-1:0] LAST = IW'(TAPS - 1);

  typedef enum logic [11:0] {
    S_CLEAR = 12'b0000_0000_0001,
    S_IDLE  = 12'b0000_0000_0010,
    S_DRD   = 12'b0000_0000_0100,
    S_DACC  = 12'b0000_0000_1000,
    S_ERR   = 12'b0000_0001_0000,
    S_PREP  = 12'b0000_0010_0000,
    S_URD   = 12'b0000_0100_0000,
    S_UMUL  = 12'b0000_1000_0000,
    S_UDIV0 = 12'b0001_0000_0000,
    S_UDIV  = 12'b0010_0000_0000,
    S_UAPP  = 12'b0100_0000_0000,
    S_FIN   = 12'b1000_0000_0000
  } state_t;

  state_t state;

  logic                        enable;
  logic [6:0]                  strength;
  logic [IW-1:0]               slot, k, h;
  logic signed [SAMPLE_W-1:0]  mic_r;
  logic                        adapt_r, pass_r;
  logic [GAIN_W-1:0]           gain_r;
  logic [9:0]                  num_step;
  logic signed [AW-1:0]        est;
  logic [EW-1:0]               energy;
  logic signed [ERRW-1:0]      err;
  logic [NW-1:0]               nue;
  logic [DW-1:0]               den;
  logic [GW-1:0]               gprod;
  logic [PW-1:0]               prod;
  logic signed [TAP_W-1:0]     tap_hold;
  logic                        neg;
  logic [CW-1:0]               rem, dsh;
  logic [Q_BITS:0]             q;
  logic [4:0]                  cnt;
  logic signed [SAMPLE_W-1:0]  out_r;
  logic                        out_v;

  // memories
  logic signed [SAMPLE_W-1:0] hist_mem [TAPS];
  logic signed [TAP_W-1:0]    tap_mem  [TAPS];
  logic signed [SAMPLE_W-1:0] hist_q;
  logic signed [TAP_W-1:0]    tap_q;
  logic                       hist_we, tap_we;
  logic [IW-1:0]              hist_wa;
  logic signed [SAMPLE_W-1:0] hist_wd;
  logic signed [TAP_W-1:0]    tap_wd;

  // combinational helpers
  logic                       in_fire, pass_now;
  logic [6:0]                 pct;
  logic [ERRW-1:0]            emag;
  logic [UE_W-1:0]            ue;
  logic [SAMPLE_W-1:0]        xmag;
  logic signed [31:0]         xsq;
  logic [CW-1:0]              rem0;
  logic signed [25:0]         upd, upd_c;
  logic [MW-1:0]              m;
  logic signed [SAMPLE_W-1:0] res;
  logic                       out_free;

  assign item.ready    = (state == S_IDLE);
  assign cfg.ready     = 1'b1;
  assign result.valid  = out_v;
  assign result.out_sample = out_r;

  assign in_fire  = item.valid && item.ready;
  assign pass_now = !enable || (strength == 7'd0);
  assign pct      = (strength > STRENGTH_MAX) ? STRENGTH_MAX : strength;
  assign out_free = !out_v || result.ready;

  assign emag = err[ERRW-1] ? ERRW'(-err) : ERRW'(err);
  assign ue   = (emag > ERRW'(UPD_ERR_LIMIT)) ? UPD_ERR_LIMIT : emag[UE_W-1:0];
  assign xmag = hist_q[SAMPLE_W-1] ? SAMPLE_W'(-hist_q) : SAMPLE_W'(hist_q);
  assign xsq  = hist_q * hist_q;
  assign rem0 = CW'(prod) + CW'(den >> 1);

  assign upd   = neg ? (26'(tap_hold) - $signed(26'(q)))
                     : (26'(tap_hold) + $signed(26'(q)));
  assign upd_c = (upd > TAP_LIMIT) ? TAP_LIMIT : ((upd < -TAP_LIMIT) ? -TAP_LIMIT : upd);

  assign m = MW'((gprod + GW'(64'd1 << 34)) >> 35);
  always_comb begin
    if (err[ERRW-1]) begin
      res = (m > MW'(32768)) ? $signed(16'h8000) : $signed(16'(~m[15:0] + 16'd1));
    end else begin
      res = (m > MW'(32767)) ? $signed(16'h7FFF) : $signed(m[15:0]);
    end
  end

  // memory write ports
  assign hist_we = (state == S_CLEAR) || (in_fire && !pass_now);
  assign hist_wa = (state == S_CLEAR) ? k : slot;
  assign hist_wd = (state == S_CLEAR) ? '0 : item.ref_sample;
  assign tap_we  = (state == S_CLEAR) || (state == S_UAPP);
  assign tap_wd  = (state == S_CLEAR) ? '0 : TAP_W'(upd_c);

  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[hist_wa] <= hist_wd;
    end
    hist_q <= hist_mem[h];
  end

  always_ff @(posedge clk) begin
    if (tap_we) begin
      tap_mem[k] <= tap_wd;
    end
    tap_q <= tap_mem[k];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      enable   <= 1'b0;
      strength <= STRENGTH_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        CFG_ENABLE:   enable   <= cfg.data[0];
        CFG_STRENGTH: strength <= cfg.data[6:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      k     <= '0;
      h     <= '0;
      slot  <= '0;
      out_v <= 1'b0;
    end else begin
      if (state == S_FIN && out_free) begin
        out_v <= 1'b1;
      end else if (out_v && result.ready) begin
        out_v <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          if (k == LAST) begin
            k     <= '0;
            state <= S_IDLE;
          end else begin
            k <= k + IW'(1);
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            mic_r    <= item.mic_sample;
            adapt_r  <= item.adapt;
            gain_r   <= item.error_gain;
            pass_r   <= pass_now;
            num_step <= STEP_BASE + {1'b0, pct, 2'b00};
            est      <= '0;
            energy   <= EW'(EPS_Q30);
            k        <= '0;
            h        <= slot;
            state    <= pass_now ? S_FIN : S_DRD;
          end
        end
        S_DRD: state <= S_DACC;
        S_DACC: begin
          est    <= est + tap_q * hist_q;
          energy <= energy + EW'($unsigned(xsq));
          if (k == LAST) begin
            state <= S_ERR;
          end else begin
            k     <= k + IW'(1);
            h     <= (h == '0) ? LAST : h - IW'(1);
            state <= S_DRD;
          end
        end
        S_ERR: begin
          err   <= (ERRW'(mic_r) <<< 20) - ERRW'(est);
          state <= S_PREP;
        end
        S_PREP: begin
          nue   <= NW'(num_step) * NW'(ue);
          den   <= DW'(STEP_DEN) * DW'(energy);
          gprod <= GW'(emag) * GW'(gain_r);
          k     <= '0;
          h     <= slot;
          state <= adapt_r ? S_URD : S_FIN;
        end
        S_URD: state <= S_UMUL;
        S_UMUL: begin
          prod     <= PW'(nue) * PW'(xmag);
          tap_hold <= tap_q;
          neg      <= err[ERRW-1] ^ hist_q[SAMPLE_W-1];
          state    <= S_UDIV0;
        end
        S_UDIV0: begin
          rem <= rem0;
          dsh <= CW'(den) << (Q_BITS - 1);
          cnt <= 5'(Q_BITS - 1);
          // quotient past the clamp range: saturate and skip the divide
          if (rem0 >= (CW'(den) << Q_BITS)) begin
            q     <= (Q_BITS + 1)'(1) << Q_BITS;
            state <= S_UAPP;
          end else begin
            q     <= '0;
            state <= S_UDIV;
          end
        end
        S_UDIV: begin
          if (rem >= dsh) begin
            rem <= rem - dsh;
            q   <= {q[Q_BITS-1:0], 1'b1};
          end else begin
            q   <= {q[Q_BITS-1:0], 1'b0};
          end
          dsh <= dsh >> 1;
          if (cnt == 5'd0) begin
            state <= S_UAPP;
          end else begin
            cnt <= cnt - 5'd1;
          end
        end
        S_UAPP: begin
          if (k == LAST) begin
            state <= S_FIN;
          end else begin
            k     <= k + IW'(1);
            h     <= (h == '0) ? LAST : h - IW'(1);
            state <= S_URD;
          end
        end
        S_FIN: begin
          // hold until the output register is free
          if (out_free) begin
            out_r <= pass_r ? mic_r : res;
            if (!pass_r) begin
              slot <= (slot == LAST) ? '0 : slot + IW'(1);
            end
            k     <= '0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_tap_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_UAPP) |-> (upd_c <= TAP_LIMIT && upd_c >= -TAP_LIMIT))
    else $error("tap write outside clamp range");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !item.ready)
    else $error("ready again right after an accepted item");

  a_quot_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_UAPP) |-> (q <= ((Q_BITS + 1)'(1) << Q_BITS)))
    else $error("tap change quotient out of range");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_v && !result.ready) |=> out_v && $stable(out_r))
    else $error("pending result overwritten");

  a_slot_only_on_finish: assert property (@(posedge clk) disable iff (rst)
    (state != S_FIN) |=> $stable(slot))
    else $error("history slot moved outside finish step");

endmodule

// ===== test/nlms_echo_canceller_unit_tb.sv =====
// Testbench for the NLMS echo canceller: directed and random sample streams
// checked against a bit-exact behavioral predictor. Depends on nec_pkg and the
// nec_item_if, nec_result_if and nec_cfg_if interfaces, and on nlms_echo_canceller_unit.
`timescale 1ns / 1ps
module nlms_echo_canceller_unit_tb;
  import nec_pkg::*;

  localparam int NTAPS = 96;
  localparam longint TAP_LIM = 1677722;
  localparam longint EPS = 42950;
  localparam longint ERR_CAP = 64'd1 << 39;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;

  nec_item_if   item ();
  nec_result_if result ();
  nec_cfg_if    cfg ();

  nlms_echo_canceller_unit #(.TAPS(NTAPS)) u_dut (
    .clk(clk), .rst(rst), .item(item), .result(result), .cfg(cfg)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  longint taps_q20 [NTAPS];
  longint hist_q15 [NTAPS];
  int     newest_slot;
  bit     cancel_on;
  int     strength;

  logic signed [15:0] expected_samples [$];
  int  error_count = 0;
  int  stall_hold = 0;
  bit  stall_random = 1'b1;

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic logic signed [15:0] predict_sample(
      logic signed [15:0] mic, logic signed [15:0] refs, bit adapt, logic [15:0] gain);
    int pct, h;
    longint est, energy, err, emag, ue, num_step, den, q, upd, m, x;
    if (!cancel_on || strength == 0) return mic;
    pct = strength > 100 ? 100 : strength;
    hist_q15[newest_slot] = refs;
    est = 0;
    energy = EPS;
    h = newest_slot;
    for (int k = 0; k < NTAPS; k++) begin
      x = hist_q15[h];
      est += taps_q20[k] * x;
      energy += x * x;
      h = (h == 0) ? NTAPS - 1 : h - 1;
    end
    err = (longint'(mic) <<< 20) - est;
    emag = mag(err);
    if (adapt) begin
      num_step = 280 + 4 * pct;
      den = 10000 * energy;
      ue = emag > ERR_CAP ? ERR_CAP : emag;
      h = newest_slot;
      for (int k = 0; k < NTAPS; k++) begin
        x = hist_q15[h];
        // product fits in 64 unsigned bits: 680*2^39*2^15 < 2^64
        q = longint'(($unsigned(num_step) * $unsigned(ue) * $unsigned(mag(x))
                      + $unsigned(den) / 2) / $unsigned(den));
        upd = taps_q20[k] + (((err < 0) != (x < 0)) ? -q : q);
        if (upd > TAP_LIM) upd = TAP_LIM;
        else if (upd < -TAP_LIM) upd = -TAP_LIM;
        taps_q20[k] = upd;
        h = (h == 0) ? NTAPS - 1 : h - 1;
      end
    end
    m = (emag * longint'(gain) + (64'd1 << 34)) >>> 35;
    newest_slot = (newest_slot + 1) % NTAPS;
    if (err < 0) return m > 32768 ? -16'sd32768 : 16'(-m);
    return m > 32767 ? 16'sd32767 : 16'(m);
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // sender: drive at falling edge, hold until accepted, then drop valid
  task automatic send_sample(logic signed [15:0] mic, logic signed [15:0] refs,
                             bit adapt, logic [15:0] gain, bit use_gaps);
    int g;
    g = use_gaps ? gap_len() : 0;
    repeat (g + 1) @(negedge clk);
    item.valid <= 1'b1;
    item.mic_sample <= mic;
    item.ref_sample <= refs;
    item.adapt <= adapt;
    item.error_gain <= gain;
    do @(posedge clk); while (!item.ready);
    expected_samples.push_back(predict_sample(mic, refs, adapt, gain));
    @(negedge clk);
    item.valid <= 1'b0;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= val;
    do @(posedge clk); while (!cfg.ready);
    if (idx == CFG_ENABLE) cancel_on = val[0];
    else if (idx == CFG_STRENGTH) strength = val[6:0];
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  // every result in, then let the block settle before touching registers
  task automatic drain();
    while (expected_samples.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  // receiver: random ready with an occasional long hold, held low while
  // stall_hold counts down, or always high when stall_random is clear
  always @(negedge clk) begin
    if (stall_hold > 0) begin
      stall_hold <= stall_hold - 1;
      result.ready <= 1'b0;
    end else if (stall_random) begin
      if ($urandom_range(0, 199) == 0) begin
        stall_hold <= $urandom_range(10, 60);
        result.ready <= 1'b0;
      end else begin
        result.ready <= ($urandom_range(0, 99) < 70);
      end
    end else begin
      result.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && result.valid && result.ready) begin
      if (expected_samples.size() == 0) begin
        $display("%0t: unexpected out_sample %0d", $time, result.out_sample);
        error_count++;
      end else begin
        if (result.out_sample !== expected_samples[0]) begin
          $display("%0t: out_sample expected %0d actual %0d", $time,
                   expected_samples[0], result.out_sample);
          error_count++;
        end
        void'(expected_samples.pop_front());
      end
    end
  end

  task automatic test_pass_through();
    send_sample(16'sh7fff, 16'sh1234, 1'b1, 16'd32768, 1'b0);
    send_sample(-16'sd32768, -16'sd32768, 1'b0, 16'd0, 1'b0);
    send_sample(16'sd5, 16'sd0, 1'b1, 16'hffff, 1'b1);
    drain();
  endtask

  task automatic test_directed_cancel();
    write_reg(CFG_ENABLE, 8'd1);
    write_reg(CFG_STRENGTH, 8'd100);
    send_sample(16'sd0, 16'sd0, 1'b1, 16'd32768, 1'b0);
    send_sample(16'sh7fff, 16'sh7fff, 1'b1, 16'd32768, 1'b0);
    send_sample(-16'sd32768, -16'sd32768, 1'b1, 16'd32768, 1'b0);
    send_sample(16'sh7fff, -16'sd32768, 1'b1, 16'hffff, 1'b0);  // gain near 2.0
    send_sample(-16'sd32768, 16'sh7fff, 1'b0, 16'hffff, 1'b0);
    send_sample(16'sd1, 16'sd0, 1'b1, 16'd1, 1'b0);
    send_sample(-16'sd1, 16'sd1, 1'b1, 16'd16384, 1'b0);
    for (int i = 0; i < 6; i++)
      send_sample(16'sh7fff, 16'sh7fff, 1'b1, 16'd65535, 1'b0);  // drive taps to the limit
    drain();
    write_reg(CFG_STRENGTH, 8'd127);  // above 100 clamps
    send_sample(16'sh4000, -16'sh4000, 1'b1, 16'd32768, 1'b0);
    drain();
    write_reg(CFG_STRENGTH, 8'd0);  // zero strength passes through
    send_sample(16'sh1111, 16'sh2222, 1'b1, 16'd0, 1'b0);
    drain();
    write_reg(CFG_IDX_SPARE, 8'hff);  // unknown index, no effect
    write_reg(CFG_STRENGTH, 8'd1);
    send_sample(16'sh1111, 16'sh2222, 1'b1, 16'd32768, 1'b0);
    drain();
  endtask

  task automatic test_random_phase(int count, int pct, bit en);
    logic signed [15:0] mic, refs;
    int r;
    write_reg(CFG_ENABLE, 8'(en));
    write_reg(CFG_STRENGTH, 8'(pct));
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 9);
      refs = (r < 2) ? 16'($urandom) : 16'sh7fff >>> $urandom_range(0, 15);
      if ($urandom_range(0, 1)) refs = -refs;
      mic = (r == 0) ? 16'($urandom) : 16'(refs >>> 1) + 16'($urandom_range(0, 255)) - 16'd128;
      send_sample(mic, refs, $urandom_range(0, 9) != 0,
                  (r < 3) ? 16'($urandom) : 16'($urandom_range(0, 32768)), 1'b1);
    end
    drain();
  endtask

  task automatic test_back_pressure();
    // long enough to outlast two full adapting items, so the input stalls
    stall_hold = 8000;
    for (int i = 0; i < 10; i++)
      send_sample(16'($urandom), 16'($urandom), 1'($urandom), 16'($urandom), 1'b0);
    drain();
    stall_random = 1'b0;
    for (int i = 0; i < 20; i++)
      send_sample(16'($urandom), 16'($urandom), 1'($urandom), 16'($urandom), 1'b0);
    stall_random = 1'b1;
    drain();
  endtask

  initial begin
    item.valid = 1'b0;
    item.mic_sample = '0;
    item.ref_sample = '0;
    item.adapt = 1'b0;
    item.error_gain = '0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    result.ready = 1'b0;
    foreach (taps_q20[i]) begin
      taps_q20[i] = 0;
      hist_q15[i] = 0;
    end
    newest_slot = 0;
    cancel_on = 1'b0;
    strength = 70;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_pass_through();
    test_directed_cancel();
    test_random_phase(200, 70, 1'b1);
    test_random_phase(100, 100, 1'b1);
    test_random_phase(50, 0, 1'b1);
    test_random_phase(50, 70, 1'b0);
    test_random_phase(200, 1, 1'b1);
    test_back_pressure();
    test_random_phase(120, 45, 1'b1);
    repeat (50) @(negedge clk);
    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #200ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/nec_pkg.sv
hw/rtl/nec_item_if.sv
hw/rtl/nec_result_if.sv
hw/rtl/nec_cfg_if.sv
hw/rtl/nlms_echo_canceller_unit.sv
test/nlms_echo_canceller_unit_tb.sv
